// ===== src/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/igli_pkg.sv =====
`default_nettype none
package igli_pkg;
  localparam int unsigned MaxKnots = 256;
  localparam int unsigned IdxW = $clog2(MaxKnots);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] RegInside = 2'd0;
  localparam logic [1:0] RegBelow  = 2'd1;
  localparam logic [1:0] RegAbove  = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [7:0]         knot_index;
    logic signed [31:0] abscissa;
    logic signed [31:0] ordinate;
  } req_t;

  typedef struct packed {
    logic signed [31:0] interpolated;
    logic [1:0]         region;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle, StRead, StCmp, StMul, StDiv, StDone
  } state_e;

  typedef struct packed {
    logic       load;      // write the request into the table
    logic       capture;   // latch query and reset scan index
    logic       rd;        // issue memory read at scan index
    logic       cmp;       // compare read data, step scan
    logic       mul_start;
    logic       div_step;
    logic       finish;    // form result into output register
  } cmd_t;

  typedef struct packed {
    logic found;    // current knot exceeds query
    logic last;     // scan index is the last knot
    logic first;    // scan index is zero
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== src/irregular_grid_linear_interpolator.sv =====
// channel  direction  handshake
// req      in         req_valid_i / req_stall_o
// rsp      out        rsp_valid_o / rsp_stall_i
// cfg      in         cfg_valid_i / cfg_ready_o
// load: writes the table. query: read and compare per knot scanned
// (one table read port); inside the grid, multiply, bit-serial divide.
// reset clears control and sets knot_count to 2; the table is undefined.
// a result waits in the output register while rsp_stall_i is high.
`default_nettype none
module irregular_grid_linear_interpolator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  output logic                req_stall_o,
  input  wire igli_pkg::req_t req_i,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output igli_pkg::rsp_t      rsp_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [8:0]     cfg_data_i
);
  logic [8:0] knot_count_q;
  igli_pkg::cmd_t cmd;
  igli_pkg::sts_t sts;
  logic busy;
  logic start;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) knot_count_q <= 9'd2;
    else if (cfg_valid_i) knot_count_q <= cfg_data_i;
  end

  assign req_stall_o = busy;
  assign start = req_valid_i && !busy;

  igli_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i(req_i.operation),
    .out_free_i(!rsp_valid_o || !rsp_stall_i), .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  igli_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .knot_count_i(knot_count_q), .cmd_i(cmd), .sts_o(sts),
    .rsp_o, .rsp_valid_o, .rsp_stall_i
  );
endmodule
`default_nettype wire

// ===== src/igli_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module igli_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          op_i,
  input  wire logic          out_free_i,
  input  wire igli_pkg::sts_t sts_i,
  output igli_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  igli_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= igli_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      igli_pkg::StIdle: begin
        if (start_i && op_i == igli_pkg::OpQuery) state_d = igli_pkg::StRead;
      end
      igli_pkg::StRead: state_d = igli_pkg::StCmp;
      igli_pkg::StCmp: begin
        if (sts_i.found && sts_i.first) state_d = igli_pkg::StDone;
        else if (sts_i.found) state_d = igli_pkg::StMul;
        else if (sts_i.last) state_d = igli_pkg::StDone;
        else state_d = igli_pkg::StRead;
      end
      igli_pkg::StMul: state_d = igli_pkg::StDiv;
      igli_pkg::StDiv: begin
        if (sts_i.div_done) state_d = igli_pkg::StDone;
      end
      igli_pkg::StDone: begin
        if (out_free_i) state_d = igli_pkg::StIdle;
      end
      default: state_d = igli_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      igli_pkg::StIdle: begin
        busy_o = 1'b0;
        cmd_o.load = start_i && op_i == igli_pkg::OpLoad;
        cmd_o.capture = start_i && op_i == igli_pkg::OpQuery;
      end
      igli_pkg::StRead: cmd_o.rd = 1'b1;
      igli_pkg::StCmp: cmd_o.cmp = 1'b1;
      igli_pkg::StMul: cmd_o.mul_start = 1'b1;
      igli_pkg::StDiv: cmd_o.div_step = 1'b1;
      igli_pkg::StDone: cmd_o.finish = out_free_i;
      default: cmd_o = '0;
    endcase
  end

  `ASSERT_NEXT(a_rd_then_cmp, clk_i, rst_ni, state_q == igli_pkg::StRead,
    state_q == igli_pkg::StCmp)
  `ASSERT_IMPL(a_idle_not_busy, clk_i, rst_ni, (state_q == igli_pkg::StIdle) == !busy_o)
  `ASSERT_NEXT(a_finish_idle, clk_i, rst_ni, cmd_o.finish, state_q == igli_pkg::StIdle)
endmodule
`default_nettype wire

// ===== src/igli_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"
module igli_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire igli_pkg::req_t     req_i,
  input  wire logic [8:0]         knot_count_i,
  input  wire igli_pkg::cmd_t     cmd_i,
  output igli_pkg::sts_t          sts_o,
  output igli_pkg::rsp_t          rsp_o,
  output logic                    rsp_valid_o,
  input  wire logic               rsp_stall_i
);
  localparam int unsigned IW = igli_pkg::IdxW;
  localparam int unsigned CW = igli_pkg::CntW;

  logic [63:0] mem_q [igli_pkg::MaxKnots];
  logic [63:0] rd_q;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] last_idx;
  logic [CW-1:0] n_eff;
  logic signed [31:0] xq_q;
  logic signed [31:0] px_q, py_q;
  logic signed [31:0] rx, ry;
  logic [31:0] offs_q, den_q, mag_q;
  logic neg_q;
  logic [63:0] prod_q;
  logic [1:0] reg_q;
  logic signed [31:0] res_q;
  logic rsp_valid_q;
  logic [1:0] cmp_reg;

  assign rx = $signed(rd_q[63:32]);
  assign ry = $signed(rd_q[31:0]);

  always_comb begin
    n_eff = knot_count_i[CW-1:0];
    if (knot_count_i == 9'd0) n_eff = CW'(1);
    if ({1'b0, knot_count_i} > 10'(igli_pkg::MaxKnots)) n_eff = CW'(igli_pkg::MaxKnots);
  end
  assign last_idx = IW'(n_eff - CW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && {1'b0, req_i.knot_index} < 9'(igli_pkg::MaxKnots)) begin
      mem_q[req_i.knot_index[IW-1:0]] <= {req_i.abscissa, req_i.ordinate};
    end
    if (cmd_i.rd) rd_q <= mem_q[idx_q];
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.capture) idx_d = '0;
    else if (cmd_i.cmp && !sts_o.found && !sts_o.last) idx_d = idx_q + IW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else idx_q <= idx_d;
  end

  assign sts_o.found = rx > xq_q;
  assign sts_o.last = idx_q == last_idx;
  assign sts_o.first = idx_q == '0;
  assign cmp_reg = sts_o.found ? igli_pkg::RegBelow : igli_pkg::RegAbove;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) xq_q <= req_i.abscissa;
    if (cmd_i.cmp) begin
      px_q <= rx;
      py_q <= ry;
      if (sts_o.found) begin
        offs_q <= 32'(xq_q - px_q);
        den_q <= 32'(rx - px_q);
        neg_q <= ry < py_q;
        mag_q <= (ry < py_q) ? 32'(py_q - ry) : 32'(ry - py_q);
        res_q <= sts_o.first ? ry : py_q;
        reg_q <= sts_o.first ? igli_pkg::RegBelow : igli_pkg::RegInside;
      end else begin
        res_q <= ry;
        reg_q <= cmp_reg;
      end
    end
    if (cmd_i.mul_start) begin
      prod_q <= 64'(offs_q) * 64'(mag_q);
    end
  end

  // restoring divider state
  logic [95:0] dv_q;
  logic [6:0] dcnt_q;
  logic dbusy_q;
  logic [32:0] dtr;
  assign dtr = dv_q[95:63] - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q <= '0;
    end else if (cmd_i.mul_start) begin
      dbusy_q <= 1'b0;
      dcnt_q <= 7'd64;
    end else if (cmd_i.div_step) begin
      if (!dbusy_q) dbusy_q <= 1'b1;
      else if (dcnt_q != 7'd0) dcnt_q <= dcnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) begin
      if (!dbusy_q) dv_q <= {32'd0, prod_q};
      else if (dcnt_q != 7'd0) begin
        if (!dtr[32]) dv_q <= {dtr[31:0], dv_q[62:0], 1'b1};
        else dv_q <= {dv_q[94:0], 1'b0};
      end
    end
  end

  logic div_fin;
  assign div_fin = dbusy_q && dcnt_q == 7'd0;
  assign sts_o.div_done = div_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_valid_q <= 1'b0;
    else if (cmd_i.finish) rsp_valid_q <= 1'b1;
    else if (!rsp_stall_i) rsp_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_o.region <= reg_q;
      if (reg_q == igli_pkg::RegInside) begin
        rsp_o.interpolated <= neg_q ? 32'(res_q - $signed(dv_q[31:0]))
                                    : 32'(res_q + $signed(dv_q[31:0]));
      end else begin
        rsp_o.interpolated <= res_q;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  `ASSERT_NEXT(a_fin_valid, clk_i, rst_ni, cmd_i.finish, rsp_valid_o)
  `ASSERT_IMPL(a_no_fin_while_full, clk_i, rst_ni, !(cmd_i.finish && rsp_valid_o && rsp_stall_i))
  `ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_o && rsp_stall_i, rsp_valid_o && $stable(rsp_o))
endmodule
`default_nettype wire
